/* hw/rtl/sliding_window_vote_debounce_unit_defines.svh */
// Assertion macros for the debounce unit.
`ifndef SLIDING_WINDOW_VOTE_DEBOUNCE_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_VOTE_DEBOUNCE_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define SWVD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SWVD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/swvd_pkg.sv */
// Shared types and constants of the debounce unit.
`default_nettype none
package swvd_pkg;

    localparam int CHANNELS_DEF    = 8;
    localparam int WINDOW_BITS_DEF = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_BEGIN  = 2'd1;
    localparam logic [1:0] KIND_CHECK  = 2'd2;

    localparam logic [1:0] CFG_WINDOW_LENGTH  = 2'd0;
    localparam logic [1:0] CFG_VOTE_THRESHOLD = 2'd1;

    localparam logic [3:0] WINDOW_LENGTH_RST  = 4'd5;
    localparam logic [3:0] VOTE_THRESHOLD_RST = 4'd3;

    typedef enum logic [2:0] {
        OP_SAMPLE,
        OP_BEGIN,
        OP_CHECK,
        OP_HOLD,
        OP_DROP
    } op_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] channel;
        logic       sample_bit;
        logic [7:0] history;
        logic [7:0] check_status;
        logic [7:0] clear_bits;
    } in_word_t;

    typedef struct packed {
        logic       changed;
        logic       level;
        logic [7:0] status;
        logic       check_hit;
    } out_word_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] channel;
        logic       sample_bit;
        logic [7:0] history;
        logic [7:0] check_status;
        logic [7:0] clear_bits;
    } cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/swvd_front.sv */
// Front end: accept input words and classify them into commands.
`default_nettype none
module swvd_front import swvd_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_data,
    input  wire logic     q_full,
    output logic          q_push,
    output cmd_t          q_cmd
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_W  = (IDX_W > 3) ? IDX_W : 3;
    localparam logic [CH_W:0] CH_LIMIT = (CH_W + 1)'(CHANNELS);

    logic [CH_W:0] ch_ext;
    logic          in_range;

    assign ch_ext   = (CH_W + 1)'(s_data.channel);
    assign in_range = (ch_ext < CH_LIMIT);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_cmd.channel      = s_data.channel;
        q_cmd.sample_bit   = s_data.sample_bit;
        q_cmd.history      = s_data.history;
        q_cmd.check_status = s_data.check_status;
        q_cmd.clear_bits   = s_data.clear_bits;
        if (!in_range) begin
            q_cmd.op = OP_DROP;
        end else begin
            case (s_data.kind)
                KIND_SAMPLE: begin
                    q_cmd.op = OP_SAMPLE;
                end
                KIND_BEGIN: begin
                    q_cmd.op = OP_BEGIN;
                end
                KIND_CHECK: begin
                    q_cmd.op = OP_CHECK;
                end
                default: begin
                    q_cmd.op = OP_HOLD;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/swvd_queue.sv */
// Short command queue between front and back ends.
`default_nettype none
module swvd_queue import swvd_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t cmd_in,
    output logic      full,
    input  wire logic pop,
    output logic      q_valid,
    output cmd_t      cmd_out
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_FULL);
    assign q_valid = (count_reg != '0);
    assign cmd_out = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/swvd_back.sv */
// Back end: channel state memory, vote logic and output register.
`default_nettype none
module swvd_back import swvd_pkg::*; #(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       q_valid,
    input  wire cmd_t       q_cmd,
    output logic            q_pop,
    input  wire logic [3:0] window_length,
    input  wire logic [3:0] vote_threshold,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_word_t       m_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_W  = (IDX_W > 3) ? IDX_W : 3;
    localparam int ENT_W = WINDOW_BITS + 9;
    localparam int CNT_W = $clog2(WINDOW_BITS + 1);

    logic [ENT_W-1:0] mem [CHANNELS];
    logic [CHANNELS-1:0] ent_ok_reg;

    cmd_t             e_cmd_reg;
    logic [IDX_W-1:0] e_idx_reg;
    logic             e_valid_reg, e_valid_next;
    logic [ENT_W-1:0] rd_data_reg;
    logic             rd_ok_reg;
    logic             fwd_reg;
    logic [ENT_W-1:0] fwd_data_reg;
    logic             m_valid_reg;
    out_word_t        m_data_reg;

    logic [CH_W-1:0]        q_ch;
    logic [IDX_W-1:0]       rd_idx;
    logic                   load_out;
    logic                   wr_en;
    logic [ENT_W-1:0]       wr_data;
    logic [ENT_W-1:0]       cur;
    logic [WINDOW_BITS-1:0] cur_win;
    logic                   cur_lvl;
    logic [7:0]             cur_st;
    logic [WINDOW_BITS-1:0] vmask;
    logic [WINDOW_BITS-1:0] samp_win;
    logic [WINDOW_BITS-1:0] beg_win;
    logic [WINDOW_BITS-1:0] vote_win;
    logic [CNT_W-1:0]       ones_cnt;
    logic                   now;
    logic [WINDOW_BITS-1:0] new_win;
    logic                   new_lvl;
    logic [7:0]             new_st;
    out_word_t              res;

    assign q_ch     = CH_W'(q_cmd.channel);
    assign rd_idx   = q_ch[IDX_W-1:0];
    assign load_out = e_valid_reg && (!m_valid_reg || m_ready);
    assign q_pop    = q_valid && (!e_valid_reg || load_out);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign cur     = fwd_reg ? fwd_data_reg : (rd_ok_reg ? rd_data_reg : '0);
    assign cur_win = cur[ENT_W-1:9];
    assign cur_lvl = cur[8];
    assign cur_st  = cur[7:0];

    always_comb begin
        for (int i = 0; i < WINDOW_BITS; i++) begin
            vmask[i] = (5'(i) < 5'(window_length));
        end
    end

    assign samp_win = {cur_win[WINDOW_BITS-2:0], e_cmd_reg.sample_bit};
    assign beg_win  = e_cmd_reg.history[WINDOW_BITS-1:0] & vmask;
    assign vote_win = ((e_cmd_reg.op == OP_BEGIN) ? beg_win : samp_win) & vmask;

    always_comb begin
        ones_cnt = '0;
        for (int i = 0; i < WINDOW_BITS; i++) begin
            ones_cnt = ones_cnt + CNT_W'(vote_win[i]);
        end
    end

    assign now = (5'(ones_cnt) >= 5'(vote_threshold));

    always_comb begin
        new_win = cur_win;
        new_lvl = cur_lvl;
        new_st  = cur_st;
        res     = '0;
        wr_en   = 1'b0;
        case (e_cmd_reg.op)
            OP_SAMPLE: begin
                new_win = samp_win;
                wr_en   = load_out;
                if (now != cur_lvl) begin
                    new_lvl     = now;
                    new_st      = {7'd0, now} + 8'd1;
                    res.changed = 1'b1;
                end
            end
            OP_BEGIN: begin
                new_win = beg_win;
                new_lvl = now;
                new_st  = '0;
                wr_en   = load_out;
            end
            OP_CHECK: begin
                wr_en = load_out;
                if (cur_st == e_cmd_reg.check_status) begin
                    new_st        = cur_st | e_cmd_reg.clear_bits;
                    res.check_hit = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (e_cmd_reg.op != OP_DROP) begin
            res.level  = new_lvl;
            res.status = new_st;
        end
    end

    assign wr_data = {new_win, new_lvl, new_st};

    always_comb begin
        e_valid_next = e_valid_reg;
        if (q_pop) begin
            e_valid_next = 1'b1;
        end else if (load_out) begin
            e_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            ent_ok_reg  <= '0;
        end else begin
            e_valid_reg <= e_valid_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (wr_en) begin
                ent_ok_reg[e_idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            e_cmd_reg    <= q_cmd;
            e_idx_reg    <= rd_idx;
            rd_data_reg  <= mem[rd_idx];
            rd_ok_reg    <= ent_ok_reg[rd_idx];
            fwd_reg      <= wr_en && (e_idx_reg == rd_idx);
            fwd_data_reg <= wr_data;
        end
        if (wr_en) begin
            mem[e_idx_reg] <= wr_data;
        end
        if (load_out) begin
            m_data_reg <= res;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/sliding_window_vote_debounce_unit.sv */
// Top level of the multi-channel threshold-vote debounce unit.
//
//  channel | direction | handshake          | word
//  s_      | in        | s_valid / s_ready  | in_word_t
//  m_      | out       | m_valid / m_ready  | out_word_t
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One word per clock sustained while m_ready holds; words pass the queue, the vote stage and the output register.
// Channel state sits in a memory read into a register as each command is popped,
// ahead of the vote, with a bypass for a word that follows on the same channel.
// Reset clears per-channel valid bits at once; no clearing pass.
// A stalled output fills the two-entry queue before s_ready drops.
`default_nettype none
`include "sliding_window_vote_debounce_unit_defines.svh"
module sliding_window_vote_debounce_unit import swvd_pkg::*; #(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_word_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_word_t       m_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [3:0] cfg_data
);

    logic [3:0] window_length_reg;
    logic [3:0] vote_threshold_reg;
    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_valid;
    cmd_t       push_cmd;
    cmd_t       head_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg  <= WINDOW_LENGTH_RST;
            vote_threshold_reg <= VOTE_THRESHOLD_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_WINDOW_LENGTH: begin
                    window_length_reg <= cfg_data;
                end
                CFG_VOTE_THRESHOLD: begin
                    vote_threshold_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    swvd_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    swvd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .cmd_in  (push_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .q_valid (q_valid),
        .cmd_out (head_cmd)
    );

    swvd_back #(
        .CHANNELS    (CHANNELS),
        .WINDOW_BITS (WINDOW_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_cmd          (head_cmd),
        .q_pop          (q_pop),
        .window_length  (window_length_reg),
        .vote_threshold (vote_threshold_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data)
    );

    `SWVD_ASSERT_SAME(a_no_push_when_full, aclk, aresetn, q_push, !q_full, "push into full queue")
    `SWVD_ASSERT_SAME(a_no_pop_when_empty, aclk, aresetn, q_pop, q_valid, "pop from empty queue")
    `SWVD_ASSERT_SAME(a_changed_not_hit, aclk, aresetn, m_valid && m_data.changed, !m_data.check_hit, "changed and check_hit together")
    `SWVD_ASSERT_NEXT(a_push_fills, aclk, aresetn, q_push && !q_pop, q_valid, "pushed word not visible")

endmodule
`default_nettype wire

/* sim/debounce_result_monitor.sv */
`timescale 1ns / 100ps
// Watches the debounce unit's channels, predicts every result word and compares it.
module debounce_result_monitor import swvd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  in_word_t   s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  out_word_t  m_data,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data,
    output int         mismatches,
    output int         outstanding,
    output int         compared
);

    logic [7:0] win_mem  [8];
    logic       lvl_mem  [8];
    logic [7:0] stat_mem [8];
    logic [3:0] win_len;
    logic [3:0] thr;
    out_word_t  awaited_words [$];
    out_word_t  want;
    int         fail_total = 0;
    int         seen_total = 0;

    function automatic logic [7:0] window_mask();
        logic [7:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (b < win_len) m[b] = 1'b1;
        end
        return m;
    endfunction

    function automatic logic vote_high(logic [7:0] win);
        logic [7:0] kept;
        int         ones;
        kept = win & window_mask();
        ones = 0;
        for (int b = 0; b < 8; b++) ones += kept[b];
        return ones >= int'(thr);
    endfunction

    function automatic out_word_t next_debounce_word(in_word_t w);
        out_word_t r;
        logic      now;
        int        c;
        r = '0;
        c = w.channel;
        case (w.kind)
            KIND_SAMPLE: begin
                win_mem[c] = {win_mem[c][6:0], w.sample_bit};
                now = vote_high(win_mem[c]);
                if (now != lvl_mem[c]) begin
                    lvl_mem[c]  = now;
                    stat_mem[c] = {7'd0, now} + 8'd1;
                    r.changed   = 1'b1;
                end
            end
            KIND_BEGIN: begin
                win_mem[c]  = w.history & window_mask();
                lvl_mem[c]  = vote_high(win_mem[c]);
                stat_mem[c] = '0;
            end
            KIND_CHECK: begin
                if (stat_mem[c] == w.check_status) begin
                    stat_mem[c] = stat_mem[c] | w.clear_bits;
                    r.check_hit = 1'b1;
                end
            end
            default: ;
        endcase
        r.level  = lvl_mem[c];
        r.status = stat_mem[c];
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
            fail_total++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < 8; c++) begin
                win_mem[c]  = '0;
                lvl_mem[c]  = 1'b0;
                stat_mem[c] = '0;
            end
            win_len = WINDOW_LENGTH_RST;
            thr     = VOTE_THRESHOLD_RST;
            awaited_words.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_WINDOW_LENGTH) win_len = cfg_data;
                else if (cfg_index == CFG_VOTE_THRESHOLD) thr = cfg_data;
            end
            if (s_valid && s_ready) awaited_words.push_back(next_debounce_word(s_data));
            if (m_valid && m_ready) begin
                seen_total++;
                if (awaited_words.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got %0h",
                             $time, m_data);
                    fail_total++;
                end else begin
                    want = awaited_words.pop_front();
                    check_field("changed", want.changed, m_data.changed);
                    check_field("level", want.level, m_data.level);
                    check_field("status", want.status, m_data.status);
                    check_field("check_hit", want.check_hit, m_data.check_hit);
                end
            end
        end
        mismatches  <= fail_total;
        outstanding <= awaited_words.size();
        compared    <= seen_total;
    end

endmodule

/* sim/tb_sliding_window_vote_debounce_unit.sv */
`timescale 1ns / 100ps
// Stimulus, register settings and verdict for the debounce unit, with its result monitor.
module tb_sliding_window_vote_debounce_unit;
    import swvd_pkg::*;

    localparam logic [1:0] KIND_SPARE   = 2'd3;
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;
    localparam int         PHASE_WORDS  = 172;
    localparam int         CYCLE_LIMIT  = 400000;

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_word_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_word_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [3:0] cfg_data  = '0;

    int mismatches;
    int outstanding;
    int compared;
    int words_sent    = 0;
    int settings_used = 1;
    int cycles        = 0;
    bit calm          = 1'b0;
    bit aim [8];

    logic [3:0] plan_len [8] = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd1, 4'd15, 4'd0, 4'd8};
    logic [3:0] plan_thr [8] = '{4'd8, 4'd0, 4'd2, 4'd9, 4'd1, 4'd15, 4'd5, 4'd4};

    sliding_window_vote_debounce_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    debounce_result_monitor watch (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .compared    (compared)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int pick_gap();
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic logic [7:0] pick_status();
        return ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_clear();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3));
    endfunction

    function automatic in_word_t any_word();
        in_word_t w;
        w.kind         = 2'($urandom_range(0, 3));
        w.channel      = 3'($urandom_range(0, 7));
        w.sample_bit   = 1'($urandom_range(0, 1));
        w.history      = 8'($urandom_range(0, 255));
        w.check_status = 8'($urandom_range(0, 255));
        w.clear_bits   = 8'($urandom_range(0, 255));
        return w;
    endfunction

    function automatic in_word_t make_word(logic [1:0] kind, logic [2:0] ch, logic b,
                                           logic [7:0] hist, logic [7:0] cmp, logic [7:0] clr);
        in_word_t w;
        w.kind         = kind;
        w.channel      = ch;
        w.sample_bit   = b;
        w.history      = hist;
        w.check_status = cmp;
        w.clear_bits   = clr;
        return w;
    endfunction

    task automatic send_word(in_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_sequence();
        in_word_t w;
        int       ch;
        int       run;
        ch   = $urandom_range(0, 7);
        calm = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 99) < 15) begin
            send_word(any_word());
        end else begin
            w         = any_word();
            w.kind    = KIND_BEGIN;
            w.channel = 3'(ch);
            send_word(w);
            run = $urandom_range(2, 24);
            for (int j = 0; j < run; j++) begin
                w = any_word();
                if ($urandom_range(0, 5) == 0) begin
                    w.kind         = KIND_CHECK;
                    w.channel      = 3'(ch);
                    w.check_status = pick_status();
                    w.clear_bits   = pick_clear();
                end else begin
                    w.kind = KIND_SAMPLE;
                    if ($urandom_range(0, 4) != 0) begin
                        w.channel = 3'(ch);
                        if ($urandom_range(0, 7) == 0) aim[ch] = !aim[ch];
                        w.sample_bit = ($urandom_range(0, 4) == 0) ? !aim[ch] : aim[ch];
                    end
                end
                send_word(w);
            end
            w              = any_word();
            w.kind         = KIND_CHECK;
            w.channel      = 3'(ch);
            w.check_status = pick_status();
            w.clear_bits   = pick_clear();
            send_word(w);
        end
    endtask

    task automatic run_phase();
        int target;
        target = words_sent + PHASE_WORDS;
        while (words_sent < target) run_sequence();
    endtask

    task automatic directed_words();
        calm = 1'b1;
        send_word(make_word(KIND_BEGIN,  3'd0, 1'b0, 8'hFF, 8'h00, 8'h00));
        send_word(make_word(KIND_CHECK,  3'd0, 1'b0, 8'h00, 8'h00, 8'hFF));
        send_word(make_word(KIND_CHECK,  3'd0, 1'b0, 8'h00, 8'h00, 8'h00));
        repeat (3) send_word(make_word(KIND_SAMPLE, 3'd0, 1'b0, 8'h00, 8'h00, 8'h00));
        send_word(make_word(KIND_CHECK,  3'd0, 1'b0, 8'h00, 8'h01, 8'h80));
        send_word(make_word(KIND_BEGIN,  3'd7, 1'b0, 8'h00, 8'h00, 8'h00));
        repeat (3) send_word(make_word(KIND_SAMPLE, 3'd7, 1'b1, 8'h00, 8'h00, 8'h00));
        send_word(make_word(KIND_CHECK,  3'd7, 1'b0, 8'h00, 8'h02, 8'h00));
        send_word(make_word(KIND_SPARE,  3'd7, 1'b1, 8'hFF, 8'hFF, 8'hFF));
        send_word(make_word(KIND_SPARE,  3'd0, 1'b0, 8'h00, 8'h00, 8'h00));
        send_word(make_word(KIND_BEGIN,  3'd3, 1'b1, 8'hAA, 8'hFF, 8'hFF));
        send_word(make_word(KIND_SAMPLE, 3'd3, 1'b1, 8'hFF, 8'hFF, 8'hFF));
        send_word(make_word(KIND_CHECK,  3'd3, 1'b1, 8'hFF, 8'hFF, 8'hFF));
        send_word(make_word(KIND_SAMPLE, 3'd5, 1'b1, 8'h00, 8'h00, 8'h00));
        send_word(make_word(KIND_BEGIN,  3'd5, 1'b0, 8'h07, 8'h00, 8'h00));
        send_word(make_word(KIND_CHECK,  3'd5, 1'b0, 8'h00, 8'h00, 8'h55));
        calm = 1'b0;
    endtask

    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_words();
        run_phase();
        for (int p = 0; p < 8; p++) begin
            settle();
            write_reg(CFG_WINDOW_LENGTH, plan_len[p]);
            write_reg(CFG_VOTE_THRESHOLD, plan_thr[p]);
            if (p == 3) begin
                write_reg(CFG_SPARE_LO, 4'hF);
                write_reg(CFG_SPARE_HI, 4'hA);
            end
            settings_used++;
            run_phase();
        end
        settle();
        write_reg(CFG_WINDOW_LENGTH, 4'($urandom_range(0, 15)));
        write_reg(CFG_VOTE_THRESHOLD, 4'($urandom_range(0, 15)));
        settings_used++;
        run_phase();
        settle();
        $display("Drove %0d words through %0d register settings, covering empty, long and",
                 words_sent, settings_used);
        $display("unreachable-threshold windows; %0d result words compared.", compared);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/swvd_pkg.sv
hw/rtl/swvd_front.sv
hw/rtl/swvd_queue.sv
hw/rtl/swvd_back.sv
hw/rtl/sliding_window_vote_debounce_unit.sv
sim/debounce_result_monitor.sv
sim/tb_sliding_window_vote_debounce_unit.sv
